// File: rtl/schema_text_tokenizer_macros.svh
// Assertion macros for the schema text tokenizer.
`ifndef SCHEMA_TEXT_TOKENIZER_MACROS_SVH
`define SCHEMA_TEXT_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define STT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");
// Next-cycle implication, checked out of reset.
`define STT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");
`else
`define STT_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define STT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/stt_pkg.sv
// Shared types, codes and character classes for the schema text tokenizer.
package stt_pkg;

    localparam int unsigned QueueDepth = 8;
    localparam int unsigned PtrW       = $clog2(QueueDepth);
    localparam int unsigned CountW     = $clog2(QueueDepth + 1);
    localparam int unsigned MaxRes     = 3;

    typedef enum logic [1:0] {
        EV_BYTE  = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2,
        EV_DONE  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        CL_PUNCT  = 2'd0,
        CL_IDENT  = 2'd1,
        CL_NUMBER = 2'd2,
        CL_STRING = 2'd3
    } class_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        class_t     cls;
        logic       first;
        logic       last;
    } result_t;

    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChLf     = 8'h0a;
    localparam logic [7:0] ChCr     = 8'h0d;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChStar   = 8'h2a;
    localparam logic [7:0] ChSlash  = 8'h2f;
    localparam logic [7:0] ChDot    = 8'h2e;
    localparam logic [7:0] ChBslash = 8'h5c;
    localparam logic [7:0] ChUscore = 8'h5f;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == ChTab || c == ChLf || c == ChCr || c == ChSpace;
    endfunction

    // = ; , { } ( )
    function automatic logic is_punct(input logic [7:0] c);
        return c == 8'h3d || c == 8'h3b || c == 8'h2c || c == 8'h7b ||
               c == 8'h7d || c == 8'h28 || c == 8'h29;
    endfunction

    function automatic result_t mk_res(input event_t ev, input logic [7:0] data,
                                       input class_t cls, input logic first);
        result_t r;
        r.ev    = ev;
        r.data  = data;
        r.cls   = cls;
        r.first = first;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/schema_text_tokenizer.sv
// Schema text tokenizer: byte-per-beat lexer with a small result queue.
`include "schema_text_tokenizer_macros.svh"

// One text byte enters per beat on the s_ channel and lands in an input
// register. When the queue has room, a single pass of lexer logic looks at
// that byte and the current mode, writes the 0 to 3 result beats it causes
// into an 8-entry result queue, and updates the mode and the sticky error
// flag. Results leave the queue on the m_ channel one beat per cycle while
// m_ready is high; a byte passes the input register and its results
// through the result queue before they are offered on m_. An input byte is
// processed whenever the queue has room for three results, so the block
// then takes a byte every cycle; the single m_ port sets the sustained
// rate when the text produces more than one result per byte (tokens of one
// byte, token ends). Whitespace and comment bytes between tokens give no
// result. Once an invalid character is reported, every byte up to the
// end-of-text beat is swallowed; the end-of-text beat always yields a
// final "text finished" result with m_last set and clears all lexer state.
module schema_text_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_event_res,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_token_class,
    output logic       m_first_byte,
    output logic       m_last
);
    import stt_pkg::*;

    // Lexer mode between bytes.
    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_IDENT  = 4'd1,
        M_NUMBER = 4'd2,
        M_STRING = 4'd3,
        M_ESCAPE = 4'd4,
        M_SLASH  = 4'd5,
        M_BLOCK  = 4'd6,
        M_STAR   = 4'd7,
        M_LINE   = 4'd8
    } mode_t;

    // Input register.
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eot_reg;

    // Lexer state.
    mode_t       mode_reg, mode_next;
    logic        err_reg, err_next;

    // Result queue.
    result_t           q_reg [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CountW-1:0] count_reg, count_next;

    logic        proc;
    logic        pop;
    result_t     res [MaxRes];
    logic [1:0]  push_n;

    // from-idle decode of the current byte
    result_t     idl_r0, idl_r1;
    logic [1:0]  idl_n;
    mode_t       idl_mode;
    logic        idl_err;

    // Process when a byte is held and the queue can take a worst-case burst.
    assign proc    = in_vld_reg && (count_reg <= CountW'(QueueDepth - MaxRes));
    assign s_ready = !in_vld_reg || proc;
    assign pop     = m_valid && m_ready;

    // Handling of a byte seen between tokens.
    always_comb begin
        logic [7:0] c;
        c        = in_byte_reg;
        idl_r0   = mk_res(EV_BYTE, c, CL_PUNCT, 1'b1);
        idl_r1   = mk_res(EV_END, 8'd0, CL_PUNCT, 1'b0);
        idl_n    = 2'd0;
        idl_mode = M_IDLE;
        idl_err  = 1'b0;
        if (is_space(c)) begin
            idl_n = 2'd0;
        end else if (is_punct(c)) begin
            idl_n = 2'd2;
        end else if (c == ChSlash) begin
            idl_mode = M_SLASH;
        end else if (is_letter(c) || c == ChUscore) begin
            idl_r0   = mk_res(EV_BYTE, c, CL_IDENT, 1'b1);
            idl_n    = 2'd1;
            idl_mode = M_IDENT;
        end else if (is_decimal(c)) begin
            idl_r0   = mk_res(EV_BYTE, c, CL_NUMBER, 1'b1);
            idl_n    = 2'd1;
            idl_mode = M_NUMBER;
        end else if (c == ChQuote) begin
            idl_r0   = mk_res(EV_BYTE, c, CL_STRING, 1'b1);
            idl_n    = 2'd1;
            idl_mode = M_STRING;
        end else begin
            idl_r0  = mk_res(EV_ERROR, 8'd0, CL_PUNCT, 1'b0);
            idl_n   = 2'd1;
            idl_err = 1'b1;
        end
    end

    // Main lexer step: results of the held byte and the next mode.
    always_comb begin
        logic [7:0] c;
        c         = in_byte_reg;
        res[0]    = mk_res(EV_DONE, 8'd0, CL_PUNCT, 1'b0);
        res[1]    = mk_res(EV_DONE, 8'd0, CL_PUNCT, 1'b0);
        res[2]    = mk_res(EV_DONE, 8'd0, CL_PUNCT, 1'b0);
        push_n    = 2'd0;
        mode_next = mode_reg;
        err_next  = err_reg;
        if (in_eot_reg) begin
            // close whatever is open, then report done
            push_n = 2'd1;
            if (!err_reg) begin
                unique case (mode_reg)
                    M_IDENT: begin
                        res[0] = mk_res(EV_END, 8'd0, CL_IDENT, 1'b0);
                        push_n = 2'd2;
                    end
                    M_NUMBER: begin
                        res[0] = mk_res(EV_END, 8'd0, CL_NUMBER, 1'b0);
                        push_n = 2'd2;
                    end
                    M_STRING, M_ESCAPE: begin
                        res[0] = mk_res(EV_END, 8'd0, CL_STRING, 1'b0);
                        push_n = 2'd2;
                    end
                    M_SLASH: begin
                        res[0] = mk_res(EV_ERROR, 8'd0, CL_PUNCT, 1'b0);
                        push_n = 2'd2;
                    end
                    default: begin
                        push_n = 2'd1;
                    end
                endcase
            end
            if (push_n == 2'd2) begin
                res[1] = mk_res(EV_DONE, 8'd0, CL_PUNCT, 1'b0);
            end
            mode_next = M_IDLE;
            err_next  = 1'b0;
        end else if (!err_reg) begin
            unique case (mode_reg)
                M_IDENT: begin
                    if (is_letter(c) || is_decimal(c) || c == ChUscore || c == ChDot) begin
                        res[0] = mk_res(EV_BYTE, c, CL_IDENT, 1'b0);
                        push_n = 2'd1;
                    end else begin
                        res[0]    = mk_res(EV_END, 8'd0, CL_IDENT, 1'b0);
                        res[1]    = idl_r0;
                        res[2]    = idl_r1;
                        push_n    = idl_n + 2'd1;
                        mode_next = idl_mode;
                        err_next  = idl_err;
                    end
                end
                M_NUMBER: begin
                    if (is_decimal(c)) begin
                        res[0] = mk_res(EV_BYTE, c, CL_NUMBER, 1'b0);
                        push_n = 2'd1;
                    end else begin
                        res[0]    = mk_res(EV_END, 8'd0, CL_NUMBER, 1'b0);
                        res[1]    = idl_r0;
                        res[2]    = idl_r1;
                        push_n    = idl_n + 2'd1;
                        mode_next = idl_mode;
                        err_next  = idl_err;
                    end
                end
                M_STRING: begin
                    res[0] = mk_res(EV_BYTE, c, CL_STRING, 1'b0);
                    push_n = 2'd1;
                    if (c == ChBslash) begin
                        mode_next = M_ESCAPE;
                    end else if (c == ChQuote) begin
                        res[1]    = mk_res(EV_END, 8'd0, CL_STRING, 1'b0);
                        push_n    = 2'd2;
                        mode_next = M_IDLE;
                    end
                end
                M_ESCAPE: begin
                    res[0]    = mk_res(EV_BYTE, c, CL_STRING, 1'b0);
                    push_n    = 2'd1;
                    mode_next = M_STRING;
                end
                M_SLASH: begin
                    if (c == ChStar) begin
                        mode_next = M_BLOCK;
                    end else if (c == ChSlash) begin
                        mode_next = M_LINE;
                    end else begin
                        // lone slash: report it, swallow this byte
                        res[0]    = mk_res(EV_ERROR, 8'd0, CL_PUNCT, 1'b0);
                        push_n    = 2'd1;
                        mode_next = M_IDLE;
                        err_next  = 1'b1;
                    end
                end
                M_BLOCK: begin
                    if (c == ChStar) begin
                        mode_next = M_STAR;
                    end
                end
                M_STAR: begin
                    if (c == ChSlash) begin
                        mode_next = M_IDLE;
                    end else if (c != ChStar) begin
                        mode_next = M_BLOCK;
                    end
                end
                M_LINE: begin
                    if (c == ChLf) begin
                        mode_next = M_IDLE;
                    end
                end
                default: begin
                    res[0]    = idl_r0;
                    res[1]    = idl_r1;
                    push_n    = idl_n;
                    mode_next = idl_mode;
                    err_next  = idl_err;
                end
            endcase
        end
        // mark the final beat of this byte
        for (int i = 0; i < MaxRes; i++) begin
            res[i].last = (2'(i) == push_n - 2'd1);
        end
    end

    assign count_next = count_reg + (proc ? CountW'(push_n) : CountW'(0))
                        - (pop ? CountW'(1) : CountW'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            mode_reg   <= M_IDLE;
            err_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (proc) begin
                in_vld_reg <= 1'b0;
            end
            if (proc) begin
                mode_reg   <= mode_next;
                err_reg    <= err_next;
                wr_ptr_reg <= wr_ptr_reg + PtrW'(push_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_next;
        end
    end

    // payload: input byte and queue entries
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_eot_reg  <= s_end_of_text;
        end
        if (proc) begin
            for (int i = 0; i < MaxRes; i++) begin
                if (2'(i) < push_n) begin
                    q_reg[wr_ptr_reg + PtrW'(i)] <= res[i];
                end
            end
        end
    end

    assign m_valid       = (count_reg != '0);
    assign m_event_res   = q_reg[rd_ptr_reg].ev;
    assign m_out_byte    = q_reg[rd_ptr_reg].data;
    assign m_token_class = q_reg[rd_ptr_reg].cls;
    assign m_first_byte  = q_reg[rd_ptr_reg].first;
    assign m_last        = q_reg[rd_ptr_reg].last;

    `STT_ASSERT_NOW(a_no_overflow, aclk, aresetn, 1'b1, count_reg <= CountW'(QueueDepth))
    `STT_ASSERT_NOW(a_eot_gives_result, aclk, aresetn, proc && in_eot_reg, push_n != 2'd0)
    `STT_ASSERT_NEXT(a_eot_clears, aclk, aresetn, proc && in_eot_reg,
                     mode_reg == M_IDLE && !err_reg)
    `STT_ASSERT_NEXT(a_err_sticky, aclk, aresetn, err_reg && !(proc && in_eot_reg), err_reg)

endmodule
